// ===== sv/mvt_pkg.sv =====
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared constants and control types for the 4x4 matrix-vector transform.
// ----------------------------------------------------------------------------
`default_nettype none

package mvt_pkg;

	localparam int ELEM_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int DIM        = 4;
	localparam int IDX_W      = 4;

	// item modes
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_XFORM = 1'b1;

	// lane stage loads
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
	} lane_ctl_t;

	// merge stage loads
	typedef struct packed {
		logic ld_s3;
		logic ld_out;
	} merge_ctl_t;

endpackage

`default_nettype wire

// ===== sv/mvt_lane.sv =====
// ----------------------------------------------------------------------------
// mvt_lane
// One matrix column times one vector element: four signed products, built
// from two half-width partial products over two pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

module mvt_lane #(
	parameter int ELEM_WIDTH = mvt_pkg::ELEM_WIDTH
) (
	input  wire                                  clk,
	input  mvt_pkg::lane_ctl_t                   ctl,
	input  wire logic signed [ELEM_WIDTH-1:0]    col [mvt_pkg::DIM],
	input  wire logic signed [ELEM_WIDTH-1:0]    vec_elem,
	output logic signed [2*ELEM_WIDTH-1:0]       prod [mvt_pkg::DIM]
);

	localparam int LO_W  = ELEM_WIDTH / 2;
	localparam int HI_W  = ELEM_WIDTH - LO_W;
	localparam int PW    = 2 * ELEM_WIDTH;
	localparam int PLO_W = ELEM_WIDTH + LO_W + 1;
	localparam int PHI_W = ELEM_WIDTH + HI_W;

	logic signed [PLO_W-1:0] plo_s1 [mvt_pkg::DIM];
	logic signed [PHI_W-1:0] phi_s1 [mvt_pkg::DIM];
	logic signed [PW-1:0]    prod_s2 [mvt_pkg::DIM];
	logic signed [LO_W:0]    vlo;
	logic signed [HI_W-1:0]  vhi;

	// low half taken as unsigned, high half carries the sign
	assign vlo = $signed({1'b0, vec_elem[LO_W-1:0]});
	assign vhi = $signed(vec_elem[ELEM_WIDTH-1:LO_W]);

	always_ff @(posedge clk) begin
		for (int i = 0; i < mvt_pkg::DIM; i++) begin
			if (ctl.ld_s1) begin
				plo_s1[i] <= col[i] * vlo;
				phi_s1[i] <= col[i] * vhi;
			end
			if (ctl.ld_s2) begin
				prod_s2[i] <= ({{LO_W{phi_s1[i][PHI_W-1]}}, phi_s1[i]} <<< LO_W)
					+ {{(PW-PLO_W){plo_s1[i][PLO_W-1]}}, plo_s1[i]};
			end
		end
	end

	assign prod = prod_s2;

endmodule

`default_nettype wire

// ===== sv/mvt_merge.sv =====
// ----------------------------------------------------------------------------
// mvt_merge
// Sums the lane products per row, scales by the fraction width and
// saturates into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mvt_merge #(
	parameter int ELEM_WIDTH = mvt_pkg::ELEM_WIDTH,
	parameter int FRAC_BITS  = mvt_pkg::FRAC_BITS
) (
	input  wire                                clk,
	input  mvt_pkg::merge_ctl_t                ctl,
	input  wire logic signed [2*ELEM_WIDTH-1:0] prod [mvt_pkg::DIM][mvt_pkg::DIM],
	output logic signed [ELEM_WIDTH-1:0]       res [mvt_pkg::DIM],
	output logic                               clip
);

	localparam int PW = 2 * ELEM_WIDTH;
	localparam int SW = PW + 2;
	localparam logic signed [SW-1:0] MAXV = {{(SW-ELEM_WIDTH+1){1'b0}}, {(ELEM_WIDTH-1){1'b1}}};
	localparam logic signed [SW-1:0] MINV = {{(SW-ELEM_WIDTH+1){1'b1}}, {(ELEM_WIDTH-1){1'b0}}};

	logic signed [SW-1:0]         sum_s3 [mvt_pkg::DIM];
	logic signed [SW-1:0]         shifted [mvt_pkg::DIM];
	logic signed [ELEM_WIDTH-1:0] sat [mvt_pkg::DIM];
	logic [mvt_pkg::DIM-1:0]      row_clip;
	logic signed [ELEM_WIDTH-1:0] res_q [mvt_pkg::DIM];
	logic                         clip_q;

	always_comb begin
		for (int i = 0; i < mvt_pkg::DIM; i++) begin
			shifted[i] = sum_s3[i] >>> FRAC_BITS;
			row_clip[i] = 1'b1;
			if (shifted[i] > MAXV) begin
				sat[i] = MAXV[ELEM_WIDTH-1:0];
			end else if (shifted[i] < MINV) begin
				sat[i] = MINV[ELEM_WIDTH-1:0];
			end else begin
				sat[i] = shifted[i][ELEM_WIDTH-1:0];
				row_clip[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < mvt_pkg::DIM; i++) begin
			if (ctl.ld_s3) begin
				sum_s3[i] <= SW'(prod[0][i]) + SW'(prod[1][i])
					+ (SW'(prod[2][i]) + SW'(prod[3][i]));
			end
			if (ctl.ld_out) begin
				res_q[i] <= sat[i];
			end
		end
		if (ctl.ld_out) begin
			clip_q <= |row_clip;
		end
	end

	assign res  = res_q;
	assign clip = clip_q;

endmodule

`default_nettype wire

// ===== sv/matrix_vector_transform.sv =====
// ----------------------------------------------------------------------------
// matrix_vector_transform
// 4x4 fixed-point transform: load items fill the column-major matrix, vector
// items give one saturated result through four lanes and a merge stage.
// ----------------------------------------------------------------------------
// A vector result passes the partial-product, product, sum and output registers in turn.
// Throughput: one item per cycle while in_ready is high, loads and vectors alike; loads give no result.
// Four pipeline stages with a valid bit each; a stalled output fills them in turn.
// Reset: asynchronous, clears the matrix to zero and empties the pipeline.
`default_nettype none

module matrix_vector_transform #(
	parameter int ELEM_WIDTH = mvt_pkg::ELEM_WIDTH,
	parameter int FRAC_BITS  = mvt_pkg::FRAC_BITS
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire                               mode,
	input  wire [mvt_pkg::IDX_W-1:0]          elem_index,
	input  wire logic signed [ELEM_WIDTH-1:0] elem_value,
	input  wire logic signed [ELEM_WIDTH-1:0] vec_x,
	input  wire logic signed [ELEM_WIDTH-1:0] vec_y,
	input  wire logic signed [ELEM_WIDTH-1:0] vec_z,
	input  wire logic signed [ELEM_WIDTH-1:0] vec_w,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic signed [ELEM_WIDTH-1:0]      out_x,
	output logic signed [ELEM_WIDTH-1:0]      out_y,
	output logic signed [ELEM_WIDTH-1:0]      out_z,
	output logic signed [ELEM_WIDTH-1:0]      out_w,
	output logic                              clipped
);

	localparam int DIM     = mvt_pkg::DIM;
	localparam int ENTRIES = DIM * DIM;

	logic signed [ELEM_WIDTH-1:0]   mat_q [ENTRIES];
	logic signed [ELEM_WIDTH-1:0]   vec [DIM];
	logic signed [ELEM_WIDTH-1:0]   col [DIM][DIM];
	logic signed [2*ELEM_WIDTH-1:0] prod [DIM][DIM];
	logic signed [ELEM_WIDTH-1:0]   res [DIM];
	logic                           clip;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic xfer_in, xfer_load, xfer_xform;
	mvt_pkg::lane_ctl_t  lane_ctl;
	mvt_pkg::merge_ctl_t merge_ctl;

	// each stage moves when the one ahead has room
	assign rdy4 = !vld_s4 || out_ready;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;

	assign in_ready   = rdy1;
	assign xfer_in    = in_valid && in_ready;
	assign xfer_load  = xfer_in && (mode == mvt_pkg::MODE_LOAD);
	assign xfer_xform = xfer_in && (mode == mvt_pkg::MODE_XFORM);

	assign lane_ctl.ld_s1   = xfer_xform;
	assign lane_ctl.ld_s2   = vld_s1 && rdy2;
	assign merge_ctl.ld_s3  = vld_s2 && rdy3;
	assign merge_ctl.ld_out = vld_s3 && rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			for (int k = 0; k < ENTRIES; k++) begin
				mat_q[k] <= '0;
			end
		end else begin
			if (rdy1) vld_s1 <= xfer_xform;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (xfer_load) begin
				mat_q[elem_index] <= elem_value;
			end
		end
	end

	assign vec[0] = vec_x;
	assign vec[1] = vec_y;
	assign vec[2] = vec_z;
	assign vec[3] = vec_w;

	// lane j holds column j: entries j*4 .. j*4+3
	always_comb begin
		for (int j = 0; j < DIM; j++) begin
			for (int i = 0; i < DIM; i++) begin
				col[j][i] = mat_q[j*DIM + i];
			end
		end
	end

	for (genvar j = 0; j < DIM; j++) begin : g_lane
		mvt_lane #(
			.ELEM_WIDTH(ELEM_WIDTH)
		) u_lane (
			.clk     (clk),
			.ctl     (lane_ctl),
			.col     (col[j]),
			.vec_elem(vec[j]),
			.prod    (prod[j])
		);
	end

	mvt_merge #(
		.ELEM_WIDTH(ELEM_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_merge (
		.clk (clk),
		.ctl (merge_ctl),
		.prod(prod),
		.res (res),
		.clip(clip)
	);

	assign out_valid = vld_s4;
	assign out_x     = res[0];
	assign out_y     = res[1];
	assign out_z     = res[2];
	assign out_w     = res[3];
	assign clipped   = clip;

	a_load_writes: assert property (@(posedge clk) disable iff (!arst_n)
		xfer_load |=> mat_q[$past(elem_index)] == $past(elem_value))
		else $error("load transfer did not update the matrix entry");

	a_xform_enters: assert property (@(posedge clk) disable iff (!arst_n)
		xfer_xform |=> vld_s1)
		else $error("vector transfer did not enter the first stage");

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && !out_ready))
		else $error("input blocked while the pipeline has room");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && !rdy4) |=> vld_s3)
		else $error("blocked sum stage lost its item");

endmodule

`default_nettype wire

// ===== tb/sv/tb_matrix_vector_transform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_vector_transform
// Drives load and vector transfers through the 4x4 transform with random gaps
// and output back-pressure. A local copy of the matrix predicts the result of each random or
// untyped vector; every result is checked in order against the output stream.
// ----------------------------------------------------------------------------

module tb_matrix_vector_transform;

	localparam int ELEM_WIDTH  = mvt_pkg::ELEM_WIDTH;
	localparam int IDX_W       = mvt_pkg::IDX_W;
	localparam int ACC_W       = 2 * ELEM_WIDTH + 2;
	localparam int RAND_ITEMS  = 730;
	localparam int HOLD_CYCLES = 80;
	localparam int WATCHDOG    = 1000;
	localparam int IDLE_PCT    = 27;

	typedef logic signed [ELEM_WIDTH-1:0] elem_t;
	typedef logic signed [ACC_W-1:0]      acc_t;

	typedef struct packed {
		logic  clip;
		elem_t x;
		elem_t y;
		elem_t z;
		elem_t w;
	} xform_res_t;

	typedef struct packed {
		logic             mode;
		logic [IDX_W-1:0] idx;
		elem_t            value;
		elem_t            vx;
		elem_t            vy;
		elem_t            vz;
		elem_t            vw;
		logic             typed;
		xform_res_t       res;
	} stim_row_t;

	localparam elem_t E_MAX = 32'sh7FFF_FFFF;
	localparam elem_t E_MIN = 32'sh8000_0000;
	localparam elem_t E_ONE = 32'sh0001_0000;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                mode;
	logic [IDX_W-1:0]    elem_index;
	elem_t               elem_value;
	elem_t               vec_x;
	elem_t               vec_y;
	elem_t               vec_z;
	elem_t               vec_w;
	logic                out_valid;
	logic                out_ready;
	elem_t               out_x;
	elem_t               out_y;
	elem_t               out_z;
	elem_t               out_w;
	logic                clipped;

	elem_t      coef_model [16];
	stim_row_t  offer_q [$];
	xform_res_t result_q [$];
	stim_row_t  dir_tab [$];
	int         mismatch_cnt;
	int         idle_run;
	logic       hold_req;
	logic       no_idle;
	logic       in_acc;
	logic       out_acc;
	stim_row_t  acc_row;
	xform_res_t want;
	xform_res_t got;

	matrix_vector_transform i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.elem_index (elem_index),
		.elem_value (elem_value),
		.vec_x      (vec_x),
		.vec_y      (vec_y),
		.vec_z      (vec_z),
		.vec_w      (vec_w),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_z      (out_z),
		.out_w      (out_w),
		.clipped    (clipped)
	);

	always #1 clk = ~clk;

	// r[i] = sum_j M[j*4+i] * v[j], floor-shifted by FRAC_BITS, saturated
	function automatic xform_res_t transform_vector(elem_t vx, elem_t vy, elem_t vz,
			elem_t vw);
		elem_t                   v [4];
		elem_t                   lane [4];
		acc_t                    acc;
		acc_t                    shifted;
		logic [ACC_W-ELEM_WIDTH:0] upper;
		xform_res_t              r;
		r = '0;
		v[0] = vx;
		v[1] = vy;
		v[2] = vz;
		v[3] = vw;
		for (int i = 0; i < mvt_pkg::DIM; i++) begin
			acc = '0;
			for (int j = 0; j < mvt_pkg::DIM; j++)
				acc = acc + acc_t'(coef_model[j*4+i]) * acc_t'(v[j]);
			shifted = acc >>> mvt_pkg::FRAC_BITS;
			upper   = shifted[ACC_W-1:ELEM_WIDTH-1];
			if (upper == '0 || upper == '1) begin
				lane[i] = shifted[ELEM_WIDTH-1:0];
			end else if (shifted[ACC_W-1]) begin
				lane[i] = E_MIN;
				r.clip  = 1'b1;
			end else begin
				lane[i] = E_MAX;
				r.clip  = 1'b1;
			end
		end
		r.x = lane[0];
		r.y = lane[1];
		r.z = lane[2];
		r.w = lane[3];
		return r;
	endfunction

	function automatic xform_res_t res_of(elem_t x, elem_t y, elem_t z, elem_t w,
			logic c);
		xform_res_t r;
		r.x    = x;
		r.y    = y;
		r.z    = z;
		r.w    = w;
		r.clip = c;
		return r;
	endfunction

	// vector fields carry junk on loads; the block must ignore them
	function automatic stim_row_t load_row(logic [IDX_W-1:0] idx, elem_t value);
		stim_row_t r;
		r       = '0;
		r.mode  = mvt_pkg::MODE_LOAD;
		r.idx   = idx;
		r.value = value;
		r.vx    = elem_t'($urandom);
		r.vy    = elem_t'($urandom);
		r.vz    = elem_t'($urandom);
		r.vw    = elem_t'($urandom);
		return r;
	endfunction

	function automatic stim_row_t xform_row(elem_t vx, elem_t vy, elem_t vz, elem_t vw,
			logic typed, xform_res_t res);
		stim_row_t r;
		r       = '0;
		r.mode  = mvt_pkg::MODE_XFORM;
		r.idx   = IDX_W'($urandom_range(0, 15));
		r.value = elem_t'($urandom);
		r.vx    = vx;
		r.vy    = vy;
		r.vz    = vz;
		r.vw    = vw;
		r.typed = typed;
		r.res   = res;
		return r;
	endfunction

	// half the values within +-4.0 so sums stay in range, the rest extremes and full-width noise
	function automatic elem_t rand_elem();
		int unsigned sel;
		sel = $urandom_range(0, 7);
		case (sel)
			0: begin
				case ($urandom_range(0, 4))
					0: return E_MAX;
					1: return E_MIN;
					2: return '0;
					3: return E_ONE;
					default: return -1;
				endcase
			end
			1, 2, 3, 4: return elem_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
			default: return elem_t'($urandom);
		endcase
	endfunction

	function automatic stim_row_t random_row();
		if ($urandom_range(0, 99) < 40)
			return load_row(IDX_W'($urandom_range(0, 15)), rand_elem());
		return xform_row(rand_elem(), rand_elem(), rand_elem(), rand_elem(), 1'b0, '0);
	endfunction

	// offers one item and returns at the edge where it transfers
	task automatic push_item(stim_row_t r);
		if (!no_idle) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		offer_q.push_back(r);
		in_valid   <= 1'b1;
		mode       <= r.mode;
		elem_index <= r.idx;
		elem_value <= r.value;
		vec_x      <= r.vx;
		vec_y      <= r.vy;
		vec_z      <= r.vz;
		vec_w      <= r.vw;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (result_q.size() != 0);
	endtask

	// output side: random back-pressure, plus one long hold on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			in_acc  = in_valid && in_ready;
			out_acc = out_valid && out_ready;
			if (out_acc) begin
				got = res_of(out_x, out_y, out_z, out_w, clipped);
				if (result_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("unexpected result: %h %h %h %h clip %b",
							out_x, out_y, out_z, out_w, clipped);
				end else begin
					want = result_q.pop_front();
					if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
							got.w !== want.w || got.clip !== want.clip) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("mismatch: exp %h %h %h %h clip %b, got %h %h %h %h clip %b",
								want.x, want.y, want.z, want.w, want.clip,
								got.x, got.y, got.z, got.w, got.clip);
					end
				end
			end
			if (in_acc) begin
				acc_row = offer_q.pop_front();
				if (mode == mvt_pkg::MODE_XFORM) begin
					if (acc_row.typed)
						result_q.push_back(acc_row.res);
					else
						result_q.push_back(transform_vector(vec_x, vec_y, vec_z, vec_w));
				end else begin
					coef_model[elem_index] = elem_value;
				end
			end
			if (in_acc || out_acc) begin
				idle_run = 0;
			end else begin
				idle_run++;
				if (idle_run >= WATCHDOG) begin
					$display("DONE: errors detected");
					$finish;
				end
			end
		end
	end

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		mode         = mvt_pkg::MODE_LOAD;
		elem_index   = '0;
		elem_value   = '0;
		vec_x        = '0;
		vec_y        = '0;
		vec_z        = '0;
		vec_w        = '0;
		hold_req     = 1'b0;
		no_idle      = 1'b0;
		mismatch_cnt = 0;
		idle_run     = 0;
		foreach (coef_model[k])
			coef_model[k] = '0;

		// fresh matrix is zero
		dir_tab.push_back(xform_row(E_MAX, E_MIN, -1, E_ONE, 1'b1, res_of(0, 0, 0, 0, 1'b0)));
		// identity
		dir_tab.push_back(load_row(0, E_ONE));
		dir_tab.push_back(load_row(5, E_ONE));
		dir_tab.push_back(load_row(10, E_ONE));
		dir_tab.push_back(load_row(15, E_ONE));
		dir_tab.push_back(xform_row(E_ONE, 32'sh0002_0000, 32'shFFFD_0000, E_MIN, 1'b1,
			res_of(E_ONE, 32'sh0002_0000, 32'shFFFD_0000, E_MIN, 1'b0)));
		dir_tab.push_back(xform_row(E_MAX, E_MIN, -1, 0, 1'b1,
			res_of(E_MAX, E_MIN, -1, 0, 1'b0)));
		// row 0 sums two max products: clips both ways
		dir_tab.push_back(load_row(0, E_MAX));
		dir_tab.push_back(load_row(4, E_MAX));
		dir_tab.push_back(xform_row(E_MAX, E_MAX, 0, 0, 1'b1, res_of(E_MAX, E_MAX, 0, 0, 1'b1)));
		dir_tab.push_back(xform_row(E_MIN, E_MIN, 0, 0, 1'b1, res_of(E_MIN, E_MIN, 0, 0, 1'b1)));
		dir_tab.push_back(load_row(0, E_MIN));
		dir_tab.push_back(load_row(4, E_MIN));
		dir_tab.push_back(xform_row(E_MIN, E_MIN, 0, 0, 1'b1, res_of(E_MAX, E_MIN, 0, 0, 1'b1)));
		// tiny negative product floors to -1 lsb
		dir_tab.push_back(load_row(15, 1));
		dir_tab.push_back(xform_row(0, 0, 0, -1, 1'b1, res_of(0, 0, 0, -1, 1'b0)));
		dir_tab.push_back(xform_row(0, 0, E_ONE, 0, 1'b1, res_of(0, 0, E_ONE, 0, 1'b0)));
		dir_tab.push_back(load_row(9, 32'shFFFF_8000));
		dir_tab.push_back(load_row(3, E_MAX));
		dir_tab.push_back(load_row(12, E_MIN));
		dir_tab.push_back(xform_row(E_ONE, -E_ONE, 32'sh0001_8000, E_MAX, 1'b0, '0));
		dir_tab.push_back(xform_row(E_MIN, E_MAX, E_MIN, E_MAX, 1'b0, '0));
		dir_tab.push_back(xform_row(32'sh0000_4000, -3, 32'sh0003_0001, -E_ONE, 1'b0, '0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[n])
			push_item(dir_tab[n]);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			// long output hold while inputs keep coming: the pipe fills and stalls
			if (n == 200)
				hold_req = 1'b1;
			if (n == 260) begin
				in_valid <= 1'b0;
				wait_drained();
			end
			no_idle = (n >= 400 && n < 560);
			push_item(random_row());
		end
		in_valid <= 1'b0;
		wait_drained();
		repeat (10) @(posedge clk);

		if (mismatch_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
